[hw/rtl/swr_pkg.sv]
`default_nettype none

package swr_pkg;

    localparam int BYTE_W       = 8;
    localparam int CFG_W        = 64;
    localparam int LEN_W        = 4;
    localparam int SWR_MAX_WORD = 8;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [CFG_W-1:0]  t_cfg_data;
    typedef logic [LEN_W-1:0]  t_len;

    // configuration register indexes
    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_WORD_BYTES = 2'd0;
    localparam t_reg_idx REG_WORD_LEN   = 2'd1;
    localparam t_reg_idx REG_REP_BYTES  = 2'd2;
    localparam t_reg_idx REG_REP_LEN    = 2'd3;

    // per-cell control
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctrl;

endpackage

`default_nettype wire

[hw/rtl/swr_cell.sv]
`default_nettype none

module swr_cell (
    input  logic               i_clk,
    input  swr_pkg::t_cell_ctrl i_ctrl,
    input  swr_pkg::t_byte     i_in_byte,
    input  swr_pkg::t_byte     i_next_byte,
    input  swr_pkg::t_byte     i_word_byte,
    output swr_pkg::t_byte     o_byte,
    output logic               o_eq
);
    import swr_pkg::*;

    t_byte r_byte;
    t_byte n_byte;

    // new byte wins over the shift from the neighbour
    always_comb begin
        n_byte = r_byte;
        if (i_ctrl.load) begin
            n_byte = i_in_byte;
        end else if (i_ctrl.shift) begin
            n_byte = i_next_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;
    assign o_eq   = (r_byte == i_word_byte);

endmodule

`default_nettype wire

[hw/rtl/stream_word_replacer.sv]
`default_nettype none

// streaming find and replace over a byte stream
//
// input channel (i_in_valid / o_in_ready) carries one text byte per transaction
// plus a flag marking the last byte of a sentence. output channel
// (o_out_valid / i_out_ready) carries one result per transaction: a byte, a
// has-byte flag (0 for a bare end marker) and a last-of-sentence flag.
// the config port (i_cfg_we, i_cfg_idx, i_cfg_data) writes the word, its
// length, the replacement and its length; write it only while idle.
//
// pending bytes sit in a row of cells that shift towards the output.
// a byte that gives at most one plain byte back is handled in its accept
// cycle, its result, if any, in the output register in the cycle after.
// a byte that gives N results otherwise (a replacement, a flush at sentence
// end, a shrunk word) moves to an emit phase, the output register draining one
// result per cycle while the receiver is ready; input is held off meanwhile.
// reset empties the window and clears the configuration: empty word, so text
// passes through unchanged. when the receiver stalls, the output register
// holds its result and no new transaction is taken in.

module stream_word_replacer #(
    parameter int MAX_WORD = swr_pkg::SWR_MAX_WORD
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // config
    input  logic              i_cfg_we,
    input  swr_pkg::t_reg_idx i_cfg_idx,
    input  swr_pkg::t_cfg_data i_cfg_data,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  swr_pkg::t_byte    i_in_byte,
    input  logic              i_sentence_end,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output swr_pkg::t_byte    o_out_byte,
    output logic              o_has_byte,
    output logic              o_last_of_sentence
);
    import swr_pkg::*;

    localparam int CW = $clog2(MAX_WORD + 1);
    localparam int IW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

    typedef enum logic {S_RUN, S_EMIT} t_state;
    typedef enum logic [1:0] {M_WIN, M_REP, M_BARE} t_mode;

    // config registers
    t_cfg_data r_word_bytes;
    t_len      r_word_length;
    t_cfg_data r_rep_bytes;
    t_len      r_rep_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_bytes  <= '0;
            r_word_length <= '0;
            r_rep_bytes   <= '0;
            r_rep_length  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WORD_BYTES: r_word_bytes  <= i_cfg_data;
                REG_WORD_LEN:   r_word_length <= i_cfg_data[LEN_W-1:0];
                REG_REP_BYTES:  r_rep_bytes   <= i_cfg_data;
                REG_REP_LEN:    r_rep_length  <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // lengths clamped to the window depth
    logic [CW-1:0] wl;
    logic [CW-1:0] rl;
    assign wl = (r_word_length > LEN_W'(MAX_WORD)) ? CW'(MAX_WORD) : CW'(r_word_length);
    assign rl = (r_rep_length > LEN_W'(MAX_WORD)) ? CW'(MAX_WORD) : CW'(r_rep_length);

    // byte views of word and replacement
    t_byte word_arr [MAX_WORD];
    t_byte rep_arr  [MAX_WORD];

    // cell row
    t_cell_ctrl          cell_ctrl [MAX_WORD];
    t_byte               cell_byte [MAX_WORD];
    logic [MAX_WORD-1:0] cell_eq;
    logic                shift_all;
    logic                load_en;
    logic [CW-1:0]       load_pos;

    for (genvar k = 0; k < MAX_WORD; k++) begin : g_cell
        t_byte next_byte;

        assign word_arr[k] = r_word_bytes[k*BYTE_W +: BYTE_W];
        assign rep_arr[k]  = r_rep_bytes[k*BYTE_W +: BYTE_W];

        if (k == MAX_WORD - 1) begin : g_tail
            assign next_byte = '0;
        end else begin : g_mid
            assign next_byte = cell_byte[k+1];
        end

        assign cell_ctrl[k].shift = shift_all;
        assign cell_ctrl[k].load  = load_en && (load_pos == CW'(k));

        swr_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (cell_ctrl[k]),
            .i_in_byte   (i_in_byte),
            .i_next_byte (next_byte),
            .i_word_byte (word_arr[k]),
            .o_byte      (cell_byte[k]),
            .o_eq        (cell_eq[k])
        );
    end

    // control state
    t_state        r_state, n_state;
    t_mode         r_mode, n_mode;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_rem, n_rem;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_end, n_end;
    logic          r_out_valid, n_out_valid;
    t_byte         r_out_byte, n_out_byte;
    logic          r_has, n_has;
    logic          r_last, n_last;

    logic          slot_free;
    logic          acc;
    logic [CW-1:0] cnt1;
    logic          in_eq;
    logic          prev_eq;
    logic          match;
    t_mode         p_mode;
    logic [CW-1:0] p_rem;
    logic          fast;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_RUN) && slot_free;
    assign acc        = i_in_valid && o_in_ready;

    // plan for the incoming byte, seen as appended to the window
    always_comb begin
        cnt1    = r_count + CW'(1);
        in_eq   = (i_in_byte == word_arr[r_count[IW-1:0]]);
        prev_eq = 1'b1;
        for (int k = 0; k < MAX_WORD; k++) begin
            if (CW'(k) < r_count && !cell_eq[k]) begin
                prev_eq = 1'b0;
            end
        end
        match = (wl != '0) && (cnt1 == wl) && in_eq && prev_eq;

        p_mode = M_WIN;
        p_rem  = '0;
        if (match) begin
            if (i_sentence_end && rl == '0) begin
                // deleted match closing a sentence: bare end marker
                p_mode = M_BARE;
                p_rem  = CW'(1);
            end else begin
                p_mode = M_REP;
                p_rem  = rl;
            end
        end else if (i_sentence_end || wl == '0) begin
            p_rem = cnt1;
        end else if (cnt1 > wl) begin
            // word shrunk: drop back to one short of the word
            p_rem = cnt1 - wl + CW'(1);
        end else if (cnt1 == wl) begin
            p_rem = CW'(1);
        end
        fast = !i_sentence_end && !match && (p_rem == CW'(1));
    end

    // next state
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_count     = r_count;
        n_rem       = r_rem;
        n_idx       = r_idx;
        n_end       = r_end;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_byte  = r_out_byte;
        n_has       = r_has;
        n_last      = r_last;
        shift_all   = 1'b0;
        load_en     = 1'b0;
        load_pos    = r_count;

        case (r_state)
            S_RUN: begin
                if (acc) begin
                    load_en = 1'b1;
                    if (fast) begin
                        // emit the oldest byte while the new one joins the row
                        shift_all   = 1'b1;
                        load_pos    = r_count - CW'(1);
                        n_out_valid = 1'b1;
                        n_out_byte  = (r_count == '0) ? i_in_byte : cell_byte[0];
                        n_has       = 1'b1;
                        n_last      = 1'b0;
                    end else begin
                        n_count = match ? '0 : cnt1;
                        n_mode  = p_mode;
                        n_rem   = p_rem;
                        n_end   = i_sentence_end;
                        n_idx   = '0;
                        if (p_rem != '0) begin
                            n_state = S_EMIT;
                        end
                    end
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_last      = r_end && (r_rem == CW'(1));
                    n_rem       = r_rem - CW'(1);
                    case (r_mode)
                        M_WIN: begin
                            n_out_byte = cell_byte[0];
                            n_has      = 1'b1;
                            shift_all  = 1'b1;
                            n_count    = r_count - CW'(1);
                        end
                        M_REP: begin
                            n_out_byte = rep_arr[r_idx];
                            n_has      = 1'b1;
                            n_idx      = r_idx + IW'(1);
                        end
                        default: begin
                            n_out_byte = '0;
                            n_has      = 1'b0;
                        end
                    endcase
                    if (r_rem == CW'(1)) begin
                        n_state = S_RUN;
                    end
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_mode      <= M_WIN;
            r_count     <= '0;
            r_rem       <= '0;
            r_idx       <= '0;
            r_end       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_count     <= n_count;
            r_rem       <= n_rem;
            r_idx       <= n_idx;
            r_end       <= n_end;
            r_out_valid <= n_out_valid;
        end
        r_out_byte <= n_out_byte;
        r_has      <= n_has;
        r_last     <= n_last;
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_byte         = r_out_byte;
    assign o_has_byte         = r_has;
    assign o_last_of_sentence = r_last;

    // window never overflows between transactions
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_count < CW'(MAX_WORD)))
        else $error("window holds too many bytes while idle");

    // window emission never runs past the stored bytes
    a_win_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_mode == M_WIN) |-> (r_rem <= r_count))
        else $error("window drain exceeds pending bytes");

    // emit phase always has work left
    a_emit_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_rem != '0))
        else $error("emit phase with nothing to emit");

    // a sentence end flushes the window completely
    a_end_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_last && $rose(r_out_valid)) |-> (r_count == '0))
        else $error("window not empty after sentence end");

endmodule

`default_nettype wire
